// File: rtl/core/lru_page_cache_lookup_macros.svh
// Assertion macros used by the page cache lookup controller.
`ifndef LRU_PAGE_CACHE_LOOKUP_MACROS_SVH
`define LRU_PAGE_CACHE_LOOKUP_MACROS_SVH

`ifndef SYNTHESIS
// Same-cycle implication.
`define LPC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Next-cycle implication.
`define LPC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define LPC_ASSERT_IMP(lbl, clk, rst, ante, cons, msg)
`define LPC_ASSERT_NXT(lbl, clk, rst, ante, cons, msg)
`endif

`endif

// File: rtl/core/lpc_pkg.sv
`timescale 1ns / 1ps

package lpc_pkg;

  localparam int NUM_PAGES_DEF       = 16;
  localparam int PAGE_BYTES_LOG2_DEF = 12;

  localparam int ADDR_W   = 32;
  localparam int LEN_W    = 13;
  localparam int PAGE_W   = 20;
  localparam int STAMP_W  = 32;
  localparam int OFFSET_W = 12;
  localparam int SLOT_W   = 4;

  // Search token walking down the row of slot cells.
  typedef struct packed {
    logic               vld;
    logic               hit;
    logic [STAMP_W-1:0] best_stamp;
  } token_t;

  // Slot update broadcast to every cell.
  typedef struct packed {
    logic               en;
    logic               miss;
    logic [PAGE_W-1:0]  page;
    logic [STAMP_W-1:0] stamp;
  } slot_wr_t;

endpackage

// File: rtl/core/lpc_cell.sv
`timescale 1ns / 1ps

module lpc_cell #(
  parameter int IDX_W    = 4,
  parameter int CELL_IDX = 0
) (
  input  logic                      clk,
  input  logic                      rst,
  input  lpc_pkg::token_t           tok_in,
  input  logic [IDX_W-1:0]          hit_idx_in,
  input  logic [IDX_W-1:0]          best_idx_in,
  input  logic [lpc_pkg::PAGE_W-1:0] lookup_page,
  input  lpc_pkg::slot_wr_t         wr,
  input  logic [IDX_W-1:0]          wr_idx,
  output lpc_pkg::token_t           tok_out,
  output logic [IDX_W-1:0]          hit_idx_out,
  output logic [IDX_W-1:0]          best_idx_out
);
  import lpc_pkg::*;

  localparam logic [IDX_W-1:0] MY_IDX  = IDX_W'(CELL_IDX);
  localparam bit               IS_HEAD = (CELL_IDX == 0);

  logic               slot_valid;
  logic [PAGE_W-1:0]  slot_page;
  logic [STAMP_W-1:0] slot_stamp;
  logic               wr_sel;
  logic               match;
  logic               take_own;

  assign wr_sel   = wr.en && (wr_idx == MY_IDX);
  assign match    = slot_valid && (slot_page == lookup_page);
  // Strict less-than keeps the lower index on a tie.
  assign take_own = IS_HEAD || (slot_stamp < tok_in.best_stamp);

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_valid <= 1'b0;
      slot_page  <= '0;
      slot_stamp <= '0;
    end else if (wr_sel) begin
      slot_stamp <= wr.stamp;
      if (wr.miss) begin
        slot_valid <= 1'b1;
        slot_page  <= wr.page;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tok_out.vld <= 1'b0;
    end else begin
      tok_out.vld <= tok_in.vld;
    end
  end

  always_ff @(posedge clk) begin
    tok_out.hit  <= tok_in.hit || match;
    hit_idx_out  <= tok_in.hit ? hit_idx_in : MY_IDX;
    if (take_own) begin
      tok_out.best_stamp <= slot_stamp;
      best_idx_out       <= MY_IDX;
    end else begin
      tok_out.best_stamp <= tok_in.best_stamp;
      best_idx_out       <= best_idx_in;
    end
  end

endmodule

// File: rtl/core/lpc_ctrl.sv
`timescale 1ns / 1ps
`include "lru_page_cache_lookup_macros.svh"

module lpc_ctrl #(
  parameter int IDX_W           = 4,
  parameter int PAGE_BYTES_LOG2 = 12
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [lpc_pkg::ADDR_W-1:0]   start_address,
  input  logic [lpc_pkg::LEN_W-1:0]    length,
  input  logic                         cfg_write,
  input  logic [lpc_pkg::ADDR_W-1:0]   cfg_data,
  output logic                         busy,
  output logic                         done,
  output logic                         rejected,
  output logic [lpc_pkg::OFFSET_W-1:0] page_offset,
  output logic                         first_hit,
  output logic [lpc_pkg::SLOT_W-1:0]   first_slot,
  output logic [lpc_pkg::PAGE_W-1:0]   first_load_page,
  output logic                         spans_two,
  output logic                         second_hit,
  output logic [lpc_pkg::SLOT_W-1:0]   second_slot,
  output logic [lpc_pkg::PAGE_W-1:0]   second_load_page,
  output lpc_pkg::token_t              seed,
  output logic [lpc_pkg::PAGE_W-1:0]   lookup_page,
  output lpc_pkg::slot_wr_t            wr,
  output logic [IDX_W-1:0]             wr_idx,
  input  lpc_pkg::token_t              tail,
  input  logic [IDX_W-1:0]             tail_hit_idx,
  input  logic [IDX_W-1:0]             tail_best_idx
);
  import lpc_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SCAN = 2'd1;
  localparam logic [1:0] ST_DONE = 2'd2;

  localparam logic [ADDR_W:0]   PAGE_BYTES  = (ADDR_W+1)'(1) << PAGE_BYTES_LOG2;
  localparam logic [ADDR_W-1:0] OFFSET_MASK = ADDR_W'(PAGE_BYTES - (ADDR_W+1)'(1));

  logic [1:0]          state;
  logic                launch;
  logic [STAMP_W-1:0]  counter;
  logic [ADDR_W-1:0]   file_size;

  logic                rej_q;
  logic [OFFSET_W-1:0] off_q;
  logic [PAGE_W-1:0]   page1_q;
  logic [PAGE_W-1:0]   cur_page;
  logic                two_q;
  logic                phase;
  logic                hit1_q;
  logic [IDX_W-1:0]    slot1_q;
  logic                hit2_q;
  logic [IDX_W-1:0]    slot2_q;

  logic                accept;
  logic [ADDR_W-1:0]   page32;
  logic [ADDR_W-1:0]   off32;
  logic [ADDR_W:0]     req_end;
  logic                bad;
  logic                crosses;

  assign busy   = (state == ST_SCAN);
  assign done   = (state == ST_DONE);
  assign accept = start && !busy;

  // Request check and split, with 33-bit adds and compares.
  always_comb begin
    page32  = start_address >> PAGE_BYTES_LOG2;
    off32   = start_address & OFFSET_MASK;
    req_end = (ADDR_W+1)'(start_address) + (ADDR_W+1)'(length);
    bad     = (length == '0) || ((ADDR_W+1)'(length) > PAGE_BYTES) ||
              (req_end > (ADDR_W+1)'(file_size));
    crosses = ((ADDR_W+1)'(off32) + (ADDR_W+1)'(length)) > PAGE_BYTES;
  end

  assign seed.vld        = launch;
  assign seed.hit        = 1'b0;
  assign seed.best_stamp = '0;
  assign lookup_page     = cur_page;

  // Slot update at the end of each scan.
  always_comb begin
    wr.en    = tail.vld;
    wr.miss  = !tail.hit;
    wr.page  = cur_page;
    wr.stamp = tail.hit ? counter : counter + 32'd1;
    wr_idx   = tail.hit ? tail_hit_idx : tail_best_idx;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      launch    <= 1'b0;
      counter   <= 32'd1;
      file_size <= '0;
    end else begin
      launch <= 1'b0;
      if (cfg_write) begin
        file_size <= cfg_data;
      end
      unique case (state)
        ST_IDLE, ST_DONE: begin
          if (accept) begin
            if (bad) begin
              state <= ST_DONE;
            end else begin
              state  <= ST_SCAN;
              launch <= 1'b1;
            end
          end else begin
            state <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          if (tail.vld) begin
            counter <= counter + (tail.hit ? 32'd1 : 32'd2);
            if (!phase && two_q) begin
              launch <= 1'b1;
            end else begin
              state <= ST_DONE;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      rej_q    <= bad;
      off_q    <= off32[OFFSET_W-1:0];
      page1_q  <= page32[PAGE_W-1:0];
      cur_page <= page32[PAGE_W-1:0];
      two_q    <= crosses;
      phase    <= 1'b0;
    end else if (busy && tail.vld) begin
      if (!phase) begin
        hit1_q <= tail.hit;
        slot1_q <= wr_idx;
        if (two_q) begin
          phase    <= 1'b1;
          cur_page <= cur_page + PAGE_W'(1);
        end
      end else begin
        hit2_q  <= tail.hit;
        slot2_q <= wr_idx;
      end
    end
  end

  always_comb begin
    rejected         = rej_q;
    page_offset      = rej_q ? '0 : off_q;
    first_hit        = !rej_q && hit1_q;
    first_slot       = rej_q ? '0 : SLOT_W'(slot1_q);
    first_load_page  = (rej_q || hit1_q) ? '0 : page1_q;
    spans_two        = !rej_q && two_q;
    second_hit       = spans_two && hit2_q;
    second_slot      = spans_two ? SLOT_W'(slot2_q) : '0;
    second_load_page = (spans_two && !hit2_q) ? page1_q + PAGE_W'(1) : '0;
  end

  `LPC_ASSERT_IMP(a_tail_in_scan, clk, rst, tail.vld, (state == ST_SCAN) && !launch, "scan token arrived outside a scan")
  `LPC_ASSERT_NXT(a_counter_step, clk, rst, wr.en, (counter == $past(counter) + 32'd1) || (counter == $past(counter) + 32'd2), "use counter moved by other than one or two")
  `LPC_ASSERT_NXT(a_second_launch, clk, rst, tail.vld && !phase && two_q, launch && (state == ST_SCAN), "second page lookup not launched")

endmodule

// File: rtl/core/lru_page_cache_lookup.sv
`timescale 1ns / 1ps
// Timing: a rejected request gives done in the cycle after start. An accepted one launches
// the search token, which is registered through each of the NUM_PAGES slot cells in turn;
// a request touching two pages launches it again, and done follows the last return.
// Throughput: one transaction per result; the next start is taken in the done cycle.
// Reset (rst, synchronous): all slots invalid with zero stamp, use counter 1, file_size 0.
// done is high for one cycle per result; the receiver cannot stall.

module lru_page_cache_lookup #(
  parameter int NUM_PAGES       = lpc_pkg::NUM_PAGES_DEF,
  parameter int PAGE_BYTES_LOG2 = lpc_pkg::PAGE_BYTES_LOG2_DEF
) (
  input  logic                         clk,
  input  logic                         rst,
  // request transaction
  input  logic                         start,
  output logic                         busy,
  input  logic [lpc_pkg::ADDR_W-1:0]   start_address,
  input  logic [lpc_pkg::LEN_W-1:0]    length,
  // file size register
  input  logic                         cfg_write,
  input  logic [lpc_pkg::ADDR_W-1:0]   cfg_data,
  // result transaction
  output logic                         done,
  output logic                         rejected,
  output logic [lpc_pkg::OFFSET_W-1:0] page_offset,
  output logic                         first_hit,
  output logic [lpc_pkg::SLOT_W-1:0]   first_slot,
  output logic [lpc_pkg::PAGE_W-1:0]   first_load_page,
  output logic                         spans_two,
  output logic                         second_hit,
  output logic [lpc_pkg::SLOT_W-1:0]   second_slot,
  output logic [lpc_pkg::PAGE_W-1:0]   second_load_page
);
  import lpc_pkg::*;

  localparam int IDX_W = $clog2(NUM_PAGES);

  // Token chain: tok[0] is the seed from the controller, tok[NUM_PAGES] the tail.
  // Each cell compares its tag against the lookup page and its stamp against the
  // running minimum, then registers the token for its neighbor.
  token_t           tok      [NUM_PAGES+1];
  logic [IDX_W-1:0] hit_idx  [NUM_PAGES+1];
  logic [IDX_W-1:0] best_idx [NUM_PAGES+1];

  logic [PAGE_W-1:0] lookup_page;
  slot_wr_t          wr;
  logic [IDX_W-1:0]  wr_idx;

  assign hit_idx[0]  = '0;
  assign best_idx[0] = '0;

  lpc_ctrl #(
    .IDX_W           (IDX_W),
    .PAGE_BYTES_LOG2 (PAGE_BYTES_LOG2)
  ) u_ctrl (
    .clk              (clk),
    .rst              (rst),
    .start            (start),
    .start_address    (start_address),
    .length           (length),
    .cfg_write        (cfg_write),
    .cfg_data         (cfg_data),
    .busy             (busy),
    .done             (done),
    .rejected         (rejected),
    .page_offset      (page_offset),
    .first_hit        (first_hit),
    .first_slot       (first_slot),
    .first_load_page  (first_load_page),
    .spans_two        (spans_two),
    .second_hit       (second_hit),
    .second_slot      (second_slot),
    .second_load_page (second_load_page),
    .seed             (tok[0]),
    .lookup_page      (lookup_page),
    .wr               (wr),
    .wr_idx           (wr_idx),
    .tail             (tok[NUM_PAGES]),
    .tail_hit_idx     (hit_idx[NUM_PAGES]),
    .tail_best_idx    (best_idx[NUM_PAGES])
  );

  // One cell per slot; the update from the controller lands in the addressed cell
  // in the same cycle the tail token arrives.
  for (genvar i = 0; i < NUM_PAGES; i++) begin : g_cell
    lpc_cell #(
      .IDX_W    (IDX_W),
      .CELL_IDX (i)
    ) u_cell (
      .clk          (clk),
      .rst          (rst),
      .tok_in       (tok[i]),
      .hit_idx_in   (hit_idx[i]),
      .best_idx_in  (best_idx[i]),
      .lookup_page  (lookup_page),
      .wr           (wr),
      .wr_idx       (wr_idx),
      .tok_out      (tok[i+1]),
      .hit_idx_out  (hit_idx[i+1]),
      .best_idx_out (best_idx[i+1])
    );
  end

endmodule
